// ===== sv/bep_pkg.sv =====
package bep_pkg;

  localparam int DEF_CORDIC_STAGES = 16;

  // Widths of the datapath. XY_W holds a negated Q2.30 vector after its CORDIC growth.
  localparam int XY_W  = 36;
  localparam int Z_W   = 34;
  localparam int MUL_W = 49;
  localparam int SAT_W = 50;

  localparam logic [32:0] TWO_PI_Q30        = 33'd6746518852;
  localparam logic [32:0] PI_Q30            = 33'd3373259426;
  localparam logic [32:0] HALF_PI_Q30       = 33'd1686629713;
  localparam logic [32:0] TWO_PI_LESS_HALF  = 33'd5059889139;

  // floor(2^62 / 2pi in Q30), used to find the number of turns in an angle.
  localparam logic [63:0] ANG_RECIP_W = (64'd1 << 62) / {31'd0, TWO_PI_Q30};
  localparam logic [29:0] ANG_RECIP   = ANG_RECIP_W[29:0];

  localparam logic signed [SAT_W-1:0] SAT_MAX = 50'sd2147483647;
  localparam logic signed [SAT_W-1:0] SAT_MIN = -50'sd2147483648;

  typedef struct packed {
    logic               upd;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] omega;
  } side_t;

  typedef struct packed {
    logic                   valid;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    side_t                  side;
  } cell_t;

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    if (v > SAT_MAX) begin
      return 32'sh7fffffff;
    end else if (v < SAT_MIN) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [29:0] atan_q30(input int i);
    logic [29:0] a;
    case (i)
      0:  a = 30'd843314857;
      1:  a = 30'd497837830;
      2:  a = 30'd263043837;
      3:  a = 30'd133525159;
      4:  a = 30'd67021687;
      5:  a = 30'd33543516;
      6:  a = 30'd16775851;
      7:  a = 30'd8388437;
      8:  a = 30'd4194283;
      9:  a = 30'd2097149;
      10: a = 30'd1048576;
      11: a = 30'd524288;
      12: a = 30'd262144;
      13: a = 30'd131072;
      14: a = 30'd65536;
      15: a = 30'd32768;
      16: a = 30'd16384;
      17: a = 30'd8192;
      18: a = 30'd4096;
      19: a = 30'd2048;
      20: a = 30'd1024;
      21: a = 30'd512;
      22: a = 30'd256;
      23: a = 30'd128;
      24: a = 30'd64;
      25: a = 30'd32;
      26: a = 30'd16;
      27: a = 30'd8;
      28: a = 30'd4;
      29: a = 30'd2;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

  // CORDIC gain in Q30 for n iterations: integer square root of prod(1 + 4^-i) in Q60.
  function automatic logic [31:0] cordic_gain(input int n);
    logic [63:0] p;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    p = 64'd1 << 60;
    for (int i = 0; i < 30; i++) begin
      if (i < n) begin
        p = p + (p >> (2 * i));
      end
    end
    v = p;
    res = 64'd0;
    bitv = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[31:0];
  endfunction

endpackage

// ===== sv/brownian_euler_particle_update_top.sv =====
// Overdamped Brownian-dynamics update of one 2D particle with an in-plane dipole.
// Input channel: an item is taken at a rising edge with start high and busy low.
// busy never rises, so a new particle may be started in every cycle.
// Result channel: out_valid is high for one cycle with the updated particle; the
// receiver cannot stall it, so every result must be taken in that cycle.
// Pipeline: gain multipliers, step sums and angle reduction, the angle fold, one
// register per CORDIC cell, then the gain correction divide; out_valid rises when
// the divide's result is registered. Throughput is one particle per cycle
// and is set by the fully pipelined multipliers and the row of CORDIC cells.
// Configuration goes through the APB port: drift_gain at 0x00, noise_gain at 0x04,
// rot_drift_gain at 0x08, rot_noise_gain at 0x0C and inv_timestep at 0x10, each
// Q16.16 and readable. Write them only while the pipeline is empty.
// Reset clears the pipeline's valid flags and sets the gains to zero and
// inv_timestep to one. Particles with in_group low come back with out_updated low,
// their position and dipole unchanged and zero rates.
module brownian_euler_particle_update_top import bep_pkg::*; #(
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_group,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_force_x,
  input  logic signed [31:0] in_force_y,
  input  logic signed [31:0] in_torque_z,
  input  logic signed [31:0] in_dir_x,
  input  logic signed [31:0] in_dir_y,
  input  logic        [15:0] in_rand_x,
  input  logic        [15:0] in_rand_y,
  input  logic        [15:0] in_rand_rot,
  output logic               out_valid,
  output logic               out_updated,
  output logic signed [31:0] out_new_pos_x,
  output logic signed [31:0] out_new_pos_y,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic signed [31:0] out_omega_z,
  output logic signed [31:0] out_new_dir_x,
  output logic signed [31:0] out_new_dir_y,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [4:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);

  localparam logic [2:0] REG_DRIFT     = 3'd0;
  localparam logic [2:0] REG_NOISE     = 3'd1;
  localparam logic [2:0] REG_ROT_DRIFT = 3'd2;
  localparam logic [2:0] REG_ROT_NOISE = 3'd3;
  localparam logic [2:0] REG_INV_DT    = 3'd4;
  localparam int LAT = CORDIC_STAGES + 11;

  typedef struct packed {
    logic               grp;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
  } carry_t;

  // Configuration registers.
  logic [31:0] drift_gain_r, noise_gain_r, rot_drift_gain_r, rot_noise_gain_r, inv_dt_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drift_gain_r     <= 32'd0;
      noise_gain_r     <= 32'd0;
      rot_drift_gain_r <= 32'd0;
      rot_noise_gain_r <= 32'd0;
      inv_dt_r         <= 32'd65536;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_DRIFT:     drift_gain_r     <= pwdata;
        REG_NOISE:     noise_gain_r     <= pwdata;
        REG_ROT_DRIFT: rot_drift_gain_r <= pwdata;
        REG_ROT_NOISE: rot_noise_gain_r <= pwdata;
        REG_INV_DT:    inv_dt_r         <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_DRIFT:     prdata = drift_gain_r;
      REG_NOISE:     prdata = noise_gain_r;
      REG_ROT_DRIFT: prdata = rot_drift_gain_r;
      REG_ROT_NOISE: prdata = rot_noise_gain_r;
      REG_INV_DT:    prdata = inv_dt_r;
      default:       prdata = 32'd0;
    endcase
  end

  // Stages one and two: gain products.
  logic signed [31:0]      nse_x, nse_y, nse_r;
  logic signed [MUL_W-1:0] m_fx, m_fy, m_tq, m_nx, m_ny, m_nr;

  assign nse_x = $signed({16'd0, in_rand_x}) - 32'sd32768;
  assign nse_y = $signed({16'd0, in_rand_y}) - 32'sd32768;
  assign nse_r = $signed({16'd0, in_rand_rot}) - 32'sd32768;

  bep_mulq16 u_mul_fx (.clk(clk), .a(in_force_x),  .b(drift_gain_r),     .p(m_fx));
  bep_mulq16 u_mul_fy (.clk(clk), .a(in_force_y),  .b(drift_gain_r),     .p(m_fy));
  bep_mulq16 u_mul_tq (.clk(clk), .a(in_torque_z), .b(rot_drift_gain_r), .p(m_tq));
  bep_mulq16 u_mul_nx (.clk(clk), .a(nse_x),       .b(noise_gain_r),     .p(m_nx));
  bep_mulq16 u_mul_ny (.clk(clk), .a(nse_y),       .b(noise_gain_r),     .p(m_ny));
  bep_mulq16 u_mul_nr (.clk(clk), .a(nse_r),       .b(rot_noise_gain_r), .p(m_nr));

  logic [5:0] vld_r;
  carry_t     c_r [0:5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 6'd0;
    end else begin
      vld_r <= {vld_r[4:0], start};
    end
  end

  // Stage three: steps and angle; stage four: positions and angle turn estimate.
  logic signed [31:0] sx3_r, sy3_r, ang3_r, ang4_r;
  logic signed [62:0] angp4_r;

  // Stage four and five: rates.
  logic signed [MUL_W-1:0] m_vx, m_vy, m_om;

  bep_mulq16 u_mul_vx (.clk(clk), .a(sx3_r),  .b(inv_dt_r), .p(m_vx));
  bep_mulq16 u_mul_vy (.clk(clk), .a(sy3_r),  .b(inv_dt_r), .p(m_vy));
  bep_mulq16 u_mul_om (.clk(clk), .a(ang3_r), .b(inv_dt_r), .p(m_om));

  logic signed [14:0] q4;
  logic signed [49:0] t5, qm5;
  logic signed [49:0] r5w;
  logic signed [36:0] r5_r;
  logic signed [36:0] r6;
  logic        [32:0] z6_r;
  logic signed [31:0] vx6_r, vy6_r, om6_r;

  assign q4  = angp4_r[62:48];
  assign t5  = $signed({{4{ang4_r[31]}}, ang4_r, 14'd0});
  assign qm5 = q4 * $signed({1'b0, TWO_PI_Q30});
  assign r5w = t5 - qm5;

  // Bring the remainder into one turn, [0, 2pi).
  always_comb begin
    if (r5_r < 37'sd0) begin
      r6 = r5_r + $signed({4'd0, TWO_PI_Q30});
    end else if (r5_r >= $signed({4'd0, TWO_PI_Q30})) begin
      r6 = r5_r - $signed({4'd0, TWO_PI_Q30});
    end else begin
      r6 = r5_r;
    end
  end

  always_ff @(posedge clk) begin
    c_r[0] <= '{grp: in_group, pos_x: in_pos_x, pos_y: in_pos_y,
                dir_x: in_dir_x, dir_y: in_dir_y};
    c_r[1] <= c_r[0];
    c_r[2] <= c_r[1];

    sx3_r  <= sat32($signed({m_fx[MUL_W-1], m_fx}) + $signed({m_nx[MUL_W-1], m_nx}));
    sy3_r  <= sat32($signed({m_fy[MUL_W-1], m_fy}) + $signed({m_ny[MUL_W-1], m_ny}));
    ang3_r <= sat32($signed({m_tq[MUL_W-1], m_tq}) + $signed({m_nr[MUL_W-1], m_nr}));

    if (c_r[2].grp) begin
      c_r[3] <= '{grp: c_r[2].grp,
                  pos_x: sat32($signed({{18{c_r[2].pos_x[31]}}, c_r[2].pos_x})
                               + $signed({{18{sx3_r[31]}}, sx3_r})),
                  pos_y: sat32($signed({{18{c_r[2].pos_y[31]}}, c_r[2].pos_y})
                               + $signed({{18{sy3_r[31]}}, sy3_r})),
                  dir_x: c_r[2].dir_x, dir_y: c_r[2].dir_y};
    end else begin
      c_r[3] <= c_r[2];
    end
    angp4_r <= ang3_r * $signed({1'b0, ANG_RECIP});
    ang4_r  <= ang3_r;

    c_r[4] <= c_r[3];
    r5_r   <= r5w[36:0];

    c_r[5] <= c_r[4];
    z6_r   <= r6[32:0];
    vx6_r  <= c_r[4].grp ? sat32($signed({m_vx[MUL_W-1], m_vx})) : 32'sd0;
    vy6_r  <= c_r[4].grp ? sat32($signed({m_vy[MUL_W-1], m_vy})) : 32'sd0;
    om6_r  <= c_r[4].grp ? sat32($signed({m_om[MUL_W-1], m_om})) : 32'sd0;
  end

  // Stage seven: fold the angle into [-pi/2, pi/2], negating the vector when folded by pi.
  cell_t                  s7_r;
  cell_t                  s7_nxt;
  logic signed [XY_W-1:0] dxe, dye;

  assign dxe = $signed({{(XY_W-32){c_r[5].dir_x[31]}}, c_r[5].dir_x});
  assign dye = $signed({{(XY_W-32){c_r[5].dir_y[31]}}, c_r[5].dir_y});

  always_comb begin
    s7_nxt.valid = vld_r[5];
    s7_nxt.side  = '{upd: c_r[5].grp, pos_x: c_r[5].pos_x, pos_y: c_r[5].pos_y,
                     vel_x: vx6_r, vel_y: vy6_r, omega: om6_r};
    s7_nxt.x = dxe;
    s7_nxt.y = dye;
    s7_nxt.z = '0;
    if (c_r[5].grp) begin
      if (z6_r <= HALF_PI_Q30) begin
        s7_nxt.z = $signed({1'b0, z6_r});
      end else if (z6_r < TWO_PI_LESS_HALF) begin
        s7_nxt.x = -dxe;
        s7_nxt.y = -dye;
        s7_nxt.z = $signed({1'b0, z6_r}) - $signed({1'b0, PI_Q30});
      end else begin
        s7_nxt.z = $signed({1'b0, z6_r}) - $signed({1'b0, TWO_PI_Q30});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_r.valid <= 1'b0;
    end else begin
      s7_r <= s7_nxt;
    end
  end

  // Row of CORDIC cells, one micro-rotation each.
  cell_t chain [0:CORDIC_STAGES];

  assign chain[0] = s7_r;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    bep_cordic_cell #(.IDX(k)) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .din  (chain[k]),
      .dout (chain[k+1])
    );
  end

  // Gain correction, with the rest of the result held alongside.
  logic signed [31:0] dir_x_res, dir_y_res;
  logic        [3:0]  vd_r;
  side_t              sd_r [0:3];

  bep_gain_div #(.CORDIC_STAGES(CORDIC_STAGES)) u_div_x (
    .clk(clk), .v(chain[CORDIC_STAGES].x), .byp(!chain[CORDIC_STAGES].side.upd),
    .res(dir_x_res)
  );

  bep_gain_div #(.CORDIC_STAGES(CORDIC_STAGES)) u_div_y (
    .clk(clk), .v(chain[CORDIC_STAGES].y), .byp(!chain[CORDIC_STAGES].side.upd),
    .res(dir_y_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 4'd0;
    end else begin
      vd_r <= {vd_r[2:0], chain[CORDIC_STAGES].valid};
    end
  end

  always_ff @(posedge clk) begin
    sd_r[0] <= chain[CORDIC_STAGES].side;
    sd_r[1] <= sd_r[0];
    sd_r[2] <= sd_r[1];
    sd_r[3] <= sd_r[2];
  end

  assign out_valid     = vd_r[3];
  assign out_updated   = sd_r[3].upd;
  assign out_new_pos_x = sd_r[3].pos_x;
  assign out_new_pos_y = sd_r[3].pos_y;
  assign out_vel_x     = sd_r[3].vel_x;
  assign out_vel_y     = sd_r[3].vel_y;
  assign out_omega_z   = sd_r[3].omega;
  assign out_new_dir_x = dir_x_res;
  assign out_new_dir_y = dir_y_res;

  // A result leaves exactly one pipeline length after its particle was started.
  a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without a particle started one pipeline length earlier");

  a_updated_from_group: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_updated) |-> $past(in_group, LAT))
    else $error("integrated result for a particle outside the group");

  a_pass_rates_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_updated) |->
      (out_vel_x == 32'sd0 && out_vel_y == 32'sd0 && out_omega_z == 32'sd0))
    else $error("passed-through particle carries non-zero rates");

endmodule

// ===== sv/bep_mulq16.sv =====
module bep_mulq16 import bep_pkg::*; (
  input  logic                    clk,
  input  logic signed [31:0]      a,
  input  logic        [31:0]      b,
  output logic signed [MUL_W-1:0] p
);

  logic              neg_r;
  logic [63:0]       prod_r;
  logic [31:0]       mag;
  logic [47:0]       rnd;
  logic [MUL_W-1:0]  p_r;

  // Sign and magnitude, so that rounding is to nearest with ties away from zero.
  assign mag = a[31] ? 32'(-a) : 32'(a);
  assign rnd = 48'((prod_r + 64'd32768) >> 16);

  always_ff @(posedge clk) begin
    neg_r  <= a[31];
    prod_r <= 64'(mag) * 64'(b);
    p_r    <= neg_r ? MUL_W'(-$signed({1'b0, rnd})) : MUL_W'($signed({1'b0, rnd}));
  end

  assign p = $signed(p_r);

endmodule

// ===== sv/bep_cordic_cell.sv =====
module bep_cordic_cell import bep_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  cell_t din,
  output cell_t dout
);

  localparam logic signed [Z_W-1:0] ANG = $signed({{(Z_W-30){1'b0}}, atan_q30(IDX)});

  cell_t                  dout_r;
  cell_t                  dout_nxt;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;

  assign xs = $signed(din.x) >>> IDX;
  assign ys = $signed(din.y) >>> IDX;

  // A particle outside the group passes its dipole through untouched.
  always_comb begin
    dout_nxt = din;
    if (din.side.upd) begin
      if (!din.z[Z_W-1]) begin
        dout_nxt.x = $signed(din.x) - ys;
        dout_nxt.y = $signed(din.y) + xs;
        dout_nxt.z = $signed(din.z) - ANG;
      end else begin
        dout_nxt.x = $signed(din.x) + ys;
        dout_nxt.y = $signed(din.y) - xs;
        dout_nxt.z = $signed(din.z) + ANG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dout_r.valid <= 1'b0;
    end else begin
      dout_r <= dout_nxt;
    end
  end

  assign dout = dout_r;

endmodule

// ===== sv/bep_gain_div.sv =====
module bep_gain_div import bep_pkg::*; #(
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
  input  logic                   clk,
  input  logic signed [XY_W-1:0] v,
  input  logic                   byp,
  output logic signed [31:0]     res
);

  localparam logic [31:0] GAIN    = cordic_gain(CORDIC_STAGES);
  localparam logic [63:0] RECIP_W = 64'h8000_0000_0000_0000 / {32'd0, GAIN};
  localparam logic [32:0] RECIP   = RECIP_W[32:0];

  logic [XY_W-1:0] mag;
  logic            big;
  logic [32:0]     mc;

  logic [65:0] prod1_r;
  logic [32:0] mc1_r;
  logic        neg1_r, big1_r, byp1_r;
  logic [31:0] raw1_r;

  logic [63:0] qg2_r;
  logic [32:0] q2_r;
  logic [32:0] mc2_r;
  logic        neg2_r, big2_r, byp2_r;
  logic [31:0] raw2_r;

  logic [63:0] num3;
  logic [63:0] rem3;
  logic [33:0] q3_r;
  logic [32:0] rem3_r;
  logic        neg3_r, big3_r, byp3_r;
  logic [31:0] raw3_r;

  logic [33:0] q4;
  logic        ovf4;
  logic [31:0] res_r;

  assign mag = v[XY_W-1] ? XY_W'(-v) : XY_W'(v);
  // Beyond 2^33 the quotient is far outside 32 bits, so only the flag is kept.
  assign big = |mag[XY_W-1:33];
  assign mc  = big ? 33'd0 : mag[32:0];

  // The reciprocal estimate is at most one low; rounding adds at most one more.
  assign num3 = {1'b0, mc2_r, 30'd0} + {33'd0, GAIN[31:1]};
  assign rem3 = num3 - qg2_r;

  assign q4   = (rem3_r >= {1'b0, GAIN}) ? q3_r + 34'd1 : q3_r;
  assign ovf4 = big3_r || (neg3_r ? (q4 > 34'h080000000) : (q4 > 34'h07fffffff));

  always_ff @(posedge clk) begin
    prod1_r <= 66'(mc) * 66'(RECIP);
    mc1_r   <= mc;
    neg1_r  <= v[XY_W-1];
    big1_r  <= big;
    byp1_r  <= byp;
    raw1_r  <= v[31:0];

    q2_r   <= prod1_r[65:33];
    qg2_r  <= 64'(prod1_r[65:33]) * 64'(GAIN);
    mc2_r  <= mc1_r;
    neg2_r <= neg1_r;
    big2_r <= big1_r;
    byp2_r <= byp1_r;
    raw2_r <= raw1_r;

    if (rem3 >= {32'd0, GAIN}) begin
      q3_r   <= {1'b0, q2_r} + 34'd1;
      rem3_r <= 33'(rem3 - {32'd0, GAIN});
    end else begin
      q3_r   <= {1'b0, q2_r};
      rem3_r <= rem3[32:0];
    end
    neg3_r <= neg2_r;
    big3_r <= big2_r;
    byp3_r <= byp2_r;
    raw3_r <= raw2_r;

    if (byp3_r) begin
      res_r <= raw3_r;
    end else if (ovf4) begin
      res_r <= neg3_r ? 32'h80000000 : 32'h7fffffff;
    end else begin
      res_r <= neg3_r ? 32'(34'd0 - q4) : q4[31:0];
    end
  end

  assign res = $signed(res_r);

endmodule
